// ===== design/atpc_pkg.sv =====
// Shared types, constants and the coefficient table for the thermal property curves.
`default_nettype none
package atpc_pkg;

    localparam int TEMP_FRAC_BITS = 16;
    localparam int OUT_FRAC_BITS  = 32;
    localparam int WORK_FRAC      = 44;
    localparam int TEMP_W         = 32;
    localparam int OUT_W          = 48;
    localparam int ACC_W          = 64;
    localparam int LANES          = 6;
    localparam int SEGS           = 4;
    localparam int TERMS          = 6;
    localparam int STEPS          = TERMS - 1;
    localparam int STEP_W         = 3;
    localparam int SEG_W          = 2;

    // |p| * |u| >> WORK_FRAC with u = T * 2^(WORK_FRAC - 10 - TEMP_FRAC_BITS)
    localparam int PROD_SHIFT     = 10 + TEMP_FRAC_BITS;
    localparam int OUT_SHIFT      = WORK_FRAC - OUT_FRAC_BITS;

    // lanes
    localparam int L_COND   = 0;
    localparam int L_COND_D = 1;
    localparam int L_HEAT   = 2;
    localparam int L_HEAT_D = 3;
    localparam int L_DENS   = 4;
    localparam int L_DENS_D = 5;

    // segment codes
    localparam logic [SEG_W-1:0] SEG_LOW  = 2'd0;
    localparam logic [SEG_W-1:0] SEG_MID  = 2'd1;
    localparam logic [SEG_W-1:0] SEG_HIGH = 2'd2;
    localparam logic [SEG_W-1:0] SEG_TOP  = 2'd3;

    typedef logic [LANES-1:0][SEGS-1:0][TERMS-1:0][ACC_W-1:0] coef_tab_t;

    typedef struct packed {
        logic [TEMP_W-1:0] temp;
        logic [SEG_W-1:0]  seg_cond;
        logic [SEG_W-1:0]  seg_heat;
        logic [SEG_W-1:0]  seg_dens;
    } meta_t;

    typedef struct packed {
        meta_t                        meta;
        logic [LANES-1:0][ACC_W-1:0]  acc;
    } item_t;

    // round(mant / 10^exp10 * 2^(WORK_FRAC + 10*k)) by restoring long division
    function automatic logic [ACC_W-1:0] coef_fix(input logic [31:0] mant,
                                                  input int exp10,
                                                  input logic neg,
                                                  input int k);
        logic [127:0] den;
        logic [127:0] r;
        logic [127:0] q;
        int           s;
        den = 128'd1;
        r   = '0;
        q   = '0;
        s   = WORK_FRAC + 10 * k;
        for (int i = 0; i < exp10; i++) begin
            den = den * 128'd10;
        end
        for (int i = 31; i >= 0; i--) begin
            r = {r[126:0], mant[i]};
            q = {q[126:0], 1'b0};
            if (r >= den) begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        for (int i = 0; i < s; i++) begin
            r = {r[126:0], 1'b0};
            q = {q[126:0], 1'b0};
            if (r >= den) begin
                r    = r - den;
                q[0] = 1'b1;
            end
        end
        if ({r[126:0], 1'b0} >= den) begin
            q = q + 128'd1;
        end
        if (neg) begin
            q = ~q + 128'd1;
        end
        return q[ACC_W-1:0];
    endfunction

    // Unused terms stay zero: a zero leading term passes through Horner exactly.
    function automatic coef_tab_t build_table();
        coef_tab_t t;
        t = '0;
        t[L_COND][SEG_LOW][0]   = coef_fix(32'd775554, 4, 1'b0, 0);
        t[L_COND][SEG_MID][0]   = coef_fix(32'd7820747, 6, 1'b0, 0);
        t[L_COND][SEG_MID][1]   = coef_fix(32'd819439, 6, 1'b0, 1);
        t[L_COND][SEG_MID][2]   = coef_fix(32'd216484, 8, 1'b1, 2);
        t[L_COND][SEG_MID][3]   = coef_fix(32'd2440757, 12, 1'b0, 3);
        t[L_COND][SEG_HIGH][0]  = coef_fix(32'd8842465, 6, 1'b1, 0);
        t[L_COND][SEG_HIGH][1]  = coef_fix(32'd644486, 6, 1'b0, 1);
        t[L_COND][SEG_HIGH][2]  = coef_fix(32'd5607477, 10, 1'b1, 2);
        t[L_COND][SEG_TOP][0]   = coef_fix(32'd167531, 3, 1'b0, 0);

        t[L_COND_D][SEG_MID][0]  = coef_fix(32'd819439, 6, 1'b0, 0);
        t[L_COND_D][SEG_MID][1]  = coef_fix(32'd432968, 8, 1'b1, 1);
        t[L_COND_D][SEG_MID][2]  = coef_fix(32'd732227, 11, 1'b0, 2);
        t[L_COND_D][SEG_HIGH][0] = coef_fix(32'd644486, 6, 1'b0, 0);
        t[L_COND_D][SEG_HIGH][1] = coef_fix(32'd11214954, 10, 1'b1, 1);

        t[L_HEAT][SEG_LOW][0]   = coef_fix(32'd57212, 2, 1'b0, 0);
        t[L_HEAT][SEG_MID][0]   = coef_fix(32'd1534967, 4, 1'b0, 0);
        t[L_HEAT][SEG_MID][1]   = coef_fix(32'd4888757, 6, 1'b0, 1);
        t[L_HEAT][SEG_MID][2]   = coef_fix(32'd128256, 7, 1'b1, 2);
        t[L_HEAT][SEG_MID][3]   = coef_fix(32'd1626604, 11, 1'b0, 3);
        t[L_HEAT][SEG_MID][4]   = coef_fix(32'd7073173, 15, 1'b1, 4);
        t[L_HEAT][SEG_HIGH][0]  = coef_fix(32'd117207, 2, 1'b0, 0);

        t[L_HEAT_D][SEG_MID][0] = coef_fix(32'd4888757, 6, 1'b0, 0);
        t[L_HEAT_D][SEG_MID][1] = coef_fix(32'd256512, 7, 1'b1, 1);
        t[L_HEAT_D][SEG_MID][2] = coef_fix(32'd4879812, 11, 1'b0, 2);
        t[L_HEAT_D][SEG_MID][3] = coef_fix(32'd28292692, 15, 1'b1, 3);

        t[L_DENS][SEG_LOW][0]   = coef_fix(32'd2754296, 3, 1'b0, 0);
        t[L_DENS][SEG_LOW][1]   = coef_fix(32'd3592712, 9, 1'b1, 1);
        t[L_DENS][SEG_MID][0]   = coef_fix(32'd2753524, 3, 1'b0, 0);
        t[L_DENS][SEG_MID][1]   = coef_fix(32'd5647875, 8, 1'b0, 1);
        t[L_DENS][SEG_MID][2]   = coef_fix(32'd1127433, 9, 1'b1, 2);
        t[L_DENS][SEG_MID][3]   = coef_fix(32'd2657999, 12, 1'b0, 3);
        t[L_DENS][SEG_MID][4]   = coef_fix(32'd3148685, 15, 1'b1, 4);
        t[L_DENS][SEG_MID][5]   = coef_fix(32'd1417919, 18, 1'b0, 5);
        t[L_DENS][SEG_HIGH][0]  = coef_fix(32'd263462, 2, 1'b0, 0);

        t[L_DENS_D][SEG_MID][0] = coef_fix(32'd5647875, 8, 1'b0, 0);
        t[L_DENS_D][SEG_MID][1] = coef_fix(32'd2254866, 9, 1'b1, 1);
        t[L_DENS_D][SEG_MID][2] = coef_fix(32'd797399, 11, 1'b0, 2);
        t[L_DENS_D][SEG_MID][3] = coef_fix(32'd1259474, 14, 1'b1, 3);
        t[L_DENS_D][SEG_MID][4] = coef_fix(32'd7089595, 18, 1'b0, 4);
        return t;
    endfunction

    localparam coef_tab_t COEF_TAB = build_table();

endpackage
`default_nettype wire

// ===== design/atpc_cell.sv =====
// One Horner step for all six curves: multiply by u, round, saturate, add the next term.
`default_nettype none
module atpc_cell (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [atpc_pkg::STEP_W-1:0]   step_k,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire atpc_pkg::item_t               in_item,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output atpc_pkg::item_t                    out_item
);

    localparam int PW   = 64;
    localparam int FW   = 96;
    localparam int AW   = atpc_pkg::ACC_W;
    localparam int TW   = atpc_pkg::TEMP_W;
    localparam int NL   = atpc_pkg::LANES;
    localparam int SEG_BITS = atpc_pkg::SEG_W;

    logic v1_reg, v2_reg, v3_reg;
    logic go1, go2, go3;

    atpc_pkg::meta_t           meta1_reg, meta2_reg;
    logic [NL-1:0][PW-1:0]     pl1_reg, ph1_reg;
    logic [NL-1:0][PW-1:0]     pl1_next, ph1_next;
    logic [NL-1:0]             neg1_reg, neg1_next;
    logic [NL-1:0][AW-1:0]     prod2_reg, prod2_next;
    atpc_pkg::item_t           item3_reg;
    logic [NL-1:0][AW-1:0]     acc3_next;

    logic [TW-1:0]             t_mag;

    assign go3      = !v3_reg || out_ready;
    assign go2      = !v2_reg || go3;
    assign go1      = !v1_reg || go2;
    assign in_ready = go1;

    // split the 64x32 magnitude product into two 32x32 partial products
    always_comb
    begin
        logic [AW-1:0] p_mag;
        t_mag = in_item.meta.temp[TW-1] ? (~in_item.meta.temp + 1'b1) : in_item.meta.temp;
        for (int l = 0; l < NL; l++) begin
            p_mag        = in_item.acc[l][AW-1] ? (~in_item.acc[l] + 1'b1) : in_item.acc[l];
            pl1_next[l]  = PW'(p_mag[31:0]) * PW'(t_mag);
            ph1_next[l]  = PW'(p_mag[AW-1:32]) * PW'(t_mag);
            neg1_next[l] = in_item.acc[l][AW-1] ^ in_item.meta.temp[TW-1];
        end
    end

    // merge, round half away from zero, saturate the magnitude, apply the sign
    always_comb
    begin
        logic [FW:0]   full;
        logic [FW:0]   m;
        logic [AW-1:0] mag;
        for (int l = 0; l < NL; l++) begin
            full = {1'b0, ph1_reg[l], 32'd0} + (FW + 1)'(pl1_reg[l])
                   + ((FW + 1)'(1) << (atpc_pkg::PROD_SHIFT - 1));
            m    = full >> atpc_pkg::PROD_SHIFT;
            if (m[FW:AW-1] != '0) begin
                mag = {1'b0, {(AW - 1){1'b1}}};
            end
            else begin
                mag = m[AW-1:0];
            end
            prod2_next[l] = neg1_reg[l] ? (~mag + 1'b1) : mag;
        end
    end

    // add the term for this step, saturating to 64 bits
    always_comb
    begin
        logic [SEG_BITS-1:0] seg;
        logic [AW-1:0]       c;
        logic [AW:0]         s;
        for (int l = 0; l < NL; l++) begin
            if (l == atpc_pkg::L_COND || l == atpc_pkg::L_COND_D) begin
                seg = meta2_reg.seg_cond;
            end
            else if (l == atpc_pkg::L_HEAT || l == atpc_pkg::L_HEAT_D) begin
                seg = meta2_reg.seg_heat;
            end
            else begin
                seg = meta2_reg.seg_dens;
            end
            c = atpc_pkg::COEF_TAB[l][seg][step_k];
            s = {prod2_reg[l][AW-1], prod2_reg[l]} + {c[AW-1], c};
            if (s[AW] != s[AW-1]) begin
                acc3_next[l] = s[AW] ? {1'b1, {(AW - 1){1'b0}}} : {1'b0, {(AW - 1){1'b1}}};
            end
            else begin
                acc3_next[l] = s[AW-1:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else begin
            if (go1) begin
                v1_reg <= in_valid;
            end
            if (go2) begin
                v2_reg <= v1_reg;
            end
            if (go3) begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go1 && in_valid) begin
            meta1_reg <= in_item.meta;
            pl1_reg   <= pl1_next;
            ph1_reg   <= ph1_next;
            neg1_reg  <= neg1_next;
        end
        if (go2 && v1_reg) begin
            meta2_reg <= meta1_reg;
            prod2_reg <= prod2_next;
        end
        if (go3 && v2_reg) begin
            item3_reg.meta <= meta2_reg;
            item3_reg.acc  <= acc3_next;
        end
    end

    assign out_valid = v3_reg;
    assign out_item  = item3_reg;

endmodule
`default_nettype wire

// ===== design/alloy_thermal_property_curves_core.sv =====
// Top level: segment select, chain of Horner cells, output rounding and saturation.
`default_nettype none
// Evaluates conductivity, specific heat and density with their slopes for one
// Q16.16 temperature per cycle while out_ready stays high. The item passes an
// entry register, five Horner cells of three register stages each and an
// output register. Each cell holds two 32x32 partial products per curve, and
// these multipliers set the stage count. Ready runs back through the whole
// chain in the same cycle, so empty stages keep filling while the output waits
// and in_ready drops only when every stage holds a request.
module alloy_thermal_property_curves_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire logic signed [31:0]  temperature,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output logic signed [47:0]       conductivity,
    output logic signed [47:0]       conductivity_slope,
    output logic signed [47:0]       heat_capacity,
    output logic signed [47:0]       heat_capacity_slope,
    output logic signed [47:0]       mass_density,
    output logic signed [47:0]       mass_density_slope,
    output logic                     bad_temperature
);

    localparam int AW = atpc_pkg::ACC_W;
    localparam int OW = atpc_pkg::OUT_W;
    localparam int NL = atpc_pkg::LANES;
    localparam int NS = atpc_pkg::STEPS;
    localparam int BW = 48;
    localparam int TOP_TERM = atpc_pkg::TERMS - 1;

    localparam logic signed [BW-1:0] B20  = BW'(20)  <<< atpc_pkg::TEMP_FRAC_BITS;
    localparam logic signed [BW-1:0] B116 = BW'(116) <<< atpc_pkg::TEMP_FRAC_BITS;
    localparam logic signed [BW-1:0] B477 = BW'(477) <<< atpc_pkg::TEMP_FRAC_BITS;
    localparam logic signed [BW-1:0] B700 = BW'(700) <<< atpc_pkg::TEMP_FRAC_BITS;

    logic                      v0_reg, vo_reg;
    logic                      go0, goo;
    atpc_pkg::item_t           item0_reg, item0_next;
    logic [NS:0]               chain_valid;
    logic [NS:0]               chain_ready;
    atpc_pkg::item_t           chain_item [NS+1];
    logic [NL-1:0][OW-1:0]     res_reg, res_next;
    logic                      bad_reg;
    logic signed [BW-1:0]      t_ext;

    assign t_ext = BW'(temperature);

    // pick each curve's segment and load its leading term
    always_comb
    begin
        logic [atpc_pkg::SEG_W-1:0] seg;
        item0_next.meta.temp = temperature;
        if (t_ext <= B116) begin
            item0_next.meta.seg_cond = atpc_pkg::SEG_LOW;
        end
        else if (t_ext <= B477) begin
            item0_next.meta.seg_cond = atpc_pkg::SEG_MID;
        end
        else if (t_ext < B700) begin
            item0_next.meta.seg_cond = atpc_pkg::SEG_HIGH;
        end
        else begin
            item0_next.meta.seg_cond = atpc_pkg::SEG_TOP;
        end
        if (t_ext <= B116) begin
            item0_next.meta.seg_heat = atpc_pkg::SEG_LOW;
        end
        else if (t_ext <= B700) begin
            item0_next.meta.seg_heat = atpc_pkg::SEG_MID;
        end
        else begin
            item0_next.meta.seg_heat = atpc_pkg::SEG_HIGH;
        end
        if (t_ext <= B20) begin
            item0_next.meta.seg_dens = atpc_pkg::SEG_LOW;
        end
        else if (t_ext <= B700) begin
            item0_next.meta.seg_dens = atpc_pkg::SEG_MID;
        end
        else begin
            item0_next.meta.seg_dens = atpc_pkg::SEG_HIGH;
        end
        for (int l = 0; l < NL; l++) begin
            if (l == atpc_pkg::L_COND || l == atpc_pkg::L_COND_D) begin
                seg = item0_next.meta.seg_cond;
            end
            else if (l == atpc_pkg::L_HEAT || l == atpc_pkg::L_HEAT_D) begin
                seg = item0_next.meta.seg_heat;
            end
            else begin
                seg = item0_next.meta.seg_dens;
            end
            item0_next.acc[l] = atpc_pkg::COEF_TAB[l][seg][TOP_TERM];
        end
    end

    assign go0      = !v0_reg || chain_ready[0];
    assign in_ready = go0;

    assign chain_valid[0] = v0_reg;
    assign chain_item[0]  = item0_reg;

    for (genvar i = 0; i < NS; i++) begin : g_cell
        atpc_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step_k    (atpc_pkg::STEP_W'(NS - 1 - i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_item   (chain_item[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_item  (chain_item[i+1])
        );
    end

    assign goo            = !vo_reg || out_ready;
    assign chain_ready[NS] = goo;

    // round half away from zero to the output format and clamp to 48 bits
    always_comb
    begin
        logic [AW-1:0] mag;
        logic [AW-1:0] m;
        logic          neg;
        for (int l = 0; l < NL; l++) begin
            neg = chain_item[NS].acc[l][AW-1];
            mag = neg ? (~chain_item[NS].acc[l] + 1'b1) : chain_item[NS].acc[l];
            m   = (mag + (AW'(1) << (atpc_pkg::OUT_SHIFT - 1))) >> atpc_pkg::OUT_SHIFT;
            if (!neg && m > AW'({1'b0, {(OW - 1){1'b1}}})) begin
                m = AW'({1'b0, {(OW - 1){1'b1}}});
            end
            if (neg && m > (AW'(1) << (OW - 1))) begin
                m = AW'(1) << (OW - 1);
            end
            res_next[l] = neg ? OW'(~m + 1'b1) : OW'(m);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            v0_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else begin
            if (go0) begin
                v0_reg <= in_valid;
            end
            if (goo) begin
                vo_reg <= chain_valid[NS];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go0 && in_valid) begin
            item0_reg <= item0_next;
        end
        if (goo && chain_valid[NS]) begin
            res_reg <= res_next;
            bad_reg <= (chain_item[NS].meta.temp[31] || chain_item[NS].meta.temp == '0);
        end
    end

    assign out_valid           = vo_reg;
    assign conductivity        = res_reg[atpc_pkg::L_COND];
    assign conductivity_slope  = res_reg[atpc_pkg::L_COND_D];
    assign heat_capacity       = res_reg[atpc_pkg::L_HEAT];
    assign heat_capacity_slope = res_reg[atpc_pkg::L_HEAT_D];
    assign mass_density        = res_reg[atpc_pkg::L_DENS];
    assign mass_density_slope  = res_reg[atpc_pkg::L_DENS_D];
    assign bad_temperature     = bad_reg;

endmodule
`default_nettype wire

// ===== dv/alloy_thermal_property_curves_core_tb.sv =====
// Self-checking testbench for the alloy thermal property curve evaluator.
`timescale 1ns / 100ps
module alloy_thermal_property_curves_core_tb;

    localparam int N_RANDOM = 830;
    localparam int HOLD_CYCLES = 120;

    typedef enum int {
        PL_COND_MID, PL_COND_MID_D, PL_COND_HI, PL_COND_HI_D,
        PL_HEAT, PL_HEAT_D, PL_DENS, PL_DENS_D, PL_DENS_LOW
    } curve_e;

    typedef struct {
        logic signed [47:0] cond;
        logic signed [47:0] cond_d;
        logic signed [47:0] heat;
        logic signed [47:0] heat_d;
        logic signed [47:0] dens;
        logic signed [47:0] dens_d;
        logic               bad;
    } props_t;

    // Directed row: typed-in flag, and whether every slope sits on a plateau.
    typedef struct {
        logic signed [31:0] temp;
        logic               bad;
        logic               flat;
    } drow_t;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic signed [31:0] temperature;
    logic               out_valid;
    logic               out_ready;
    logic signed [47:0] conductivity;
    logic signed [47:0] conductivity_slope;
    logic signed [47:0] heat_capacity;
    logic signed [47:0] heat_capacity_slope;
    logic signed [47:0] mass_density;
    logic signed [47:0] mass_density_slope;
    logic               bad_temperature;

    props_t pending_props[$];
    int     errors;
    int     n_sent;
    int     n_checked;
    int     n_bad_seen;
    logic   hold_out;
    logic   no_idle;

    alloy_thermal_property_curves_core u_dut (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (in_valid),
        .in_ready            (in_ready),
        .temperature         (temperature),
        .out_valid           (out_valid),
        .out_ready           (out_ready),
        .conductivity        (conductivity),
        .conductivity_slope  (conductivity_slope),
        .heat_capacity       (heat_capacity),
        .heat_capacity_slope (heat_capacity_slope),
        .mass_density        (mass_density),
        .mass_density_slope  (mass_density_slope),
        .bad_temperature     (bad_temperature)
    );

    always #4 clk = ~clk;

    // round(mant / 10^e * 2^(44 + 10k)), half up
    function automatic longint fix_coef(longint unsigned mant, int e, bit neg, int k);
        logic [127:0] num;
        logic [127:0] den;
        logic [127:0] q;
        logic [127:0] r;
        num = 128'(mant) << (atpc_pkg::WORK_FRAC + 10 * k);
        den = 128'd1;
        for (int i = 0; i < e; i++)
        begin
            den = den * 128'd10;
        end
        q = num / den;
        r = num % den;
        if ((r << 1) >= den)
        begin
            q = q + 128'd1;
        end
        return neg ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint curve_coef(curve_e c, int k);
        case (c)
            PL_COND_MID:
                case (k)
                    0: return fix_coef(7820747, 6, 0, 0);
                    1: return fix_coef(819439, 6, 0, 1);
                    2: return fix_coef(216484, 8, 1, 2);
                    default: return fix_coef(2440757, 12, 0, 3);
                endcase
            PL_COND_MID_D:
                case (k)
                    0: return fix_coef(819439, 6, 0, 0);
                    1: return fix_coef(432968, 8, 1, 1);
                    default: return fix_coef(732227, 11, 0, 2);
                endcase
            PL_COND_HI:
                case (k)
                    0: return fix_coef(8842465, 6, 1, 0);
                    1: return fix_coef(644486, 6, 0, 1);
                    default: return fix_coef(5607477, 10, 1, 2);
                endcase
            PL_COND_HI_D:
                return (k == 0) ? fix_coef(644486, 6, 0, 0) : fix_coef(11214954, 10, 1, 1);
            PL_HEAT:
                case (k)
                    0: return fix_coef(1534967, 4, 0, 0);
                    1: return fix_coef(4888757, 6, 0, 1);
                    2: return fix_coef(128256, 7, 1, 2);
                    3: return fix_coef(1626604, 11, 0, 3);
                    default: return fix_coef(7073173, 15, 1, 4);
                endcase
            PL_HEAT_D:
                case (k)
                    0: return fix_coef(4888757, 6, 0, 0);
                    1: return fix_coef(256512, 7, 1, 1);
                    2: return fix_coef(4879812, 11, 0, 2);
                    default: return fix_coef(28292692, 15, 1, 3);
                endcase
            PL_DENS:
                case (k)
                    0: return fix_coef(2753524, 3, 0, 0);
                    1: return fix_coef(5647875, 8, 0, 1);
                    2: return fix_coef(1127433, 9, 1, 2);
                    3: return fix_coef(2657999, 12, 0, 3);
                    4: return fix_coef(3148685, 15, 1, 4);
                    default: return fix_coef(1417919, 18, 0, 5);
                endcase
            PL_DENS_D:
                case (k)
                    0: return fix_coef(5647875, 8, 0, 0);
                    1: return fix_coef(2254866, 9, 1, 1);
                    2: return fix_coef(797399, 11, 0, 2);
                    3: return fix_coef(1259474, 14, 1, 3);
                    default: return fix_coef(7089595, 18, 0, 4);
                endcase
            default:
                return (k == 0) ? fix_coef(2754296, 3, 0, 0) : fix_coef(3592712, 9, 1, 1);
        endcase
    endfunction

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint mul_round(longint a, longint b);
        logic [127:0] prod;
        logic [127:0] hi;
        longint       res;
        prod = 128'(magnitude(a)) * 128'(magnitude(b))
               + (128'd1 << (atpc_pkg::WORK_FRAC - 1));
        hi   = prod >> atpc_pkg::WORK_FRAC;
        if (hi > 128'h7FFF_FFFF_FFFF_FFFF)
        begin
            res = 64'h7FFF_FFFF_FFFF_FFFF;
        end
        else
        begin
            res = longint'(hi[63:0]);
        end
        return ((a < 0) != (b < 0)) ? -res : res;
    endfunction

    function automatic longint add_clamp(longint a, longint b);
        logic signed [64:0] s;
        s = 65'(a) + 65'(b);
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF)
        begin
            return 64'h7FFF_FFFF_FFFF_FFFF;
        end
        if (s < -65'sh0_8000_0000_0000_0000)
        begin
            return 64'h8000_0000_0000_0000;
        end
        return longint'(s[63:0]);
    endfunction

    function automatic longint eval_curve(curve_e c, int n, longint u);
        longint p;
        p = curve_coef(c, n - 1);
        for (int k = n - 2; k >= 0; k--)
        begin
            p = add_clamp(mul_round(p, u), curve_coef(c, k));
        end
        return p;
    endfunction

    // Q.44 to Q16.32, half away from zero, clamp to 48 bits
    function automatic logic signed [47:0] to_q16_32(longint v);
        logic [63:0] m;
        m = (magnitude(v) + (64'd1 << (atpc_pkg::OUT_SHIFT - 1))) >> atpc_pkg::OUT_SHIFT;
        if (v >= 0)
        begin
            if (m > 64'h7FFF_FFFF_FFFF)
            begin
                m = 64'h7FFF_FFFF_FFFF;
            end
            return m[47:0];
        end
        if (m > 64'h8000_0000_0000)
        begin
            m = 64'h8000_0000_0000;
        end
        return 48'(-m);
    endfunction

    function automatic props_t predict_props(logic signed [31:0] t);
        props_t p;
        longint tv;
        longint u;
        longint b20;
        longint b116;
        longint b477;
        longint b700;
        longint kc;
        longint kd;
        longint hc;
        longint hd;
        longint dc;
        longint dd;
        tv   = longint'(t);
        u    = tv * (longint'(1) << (atpc_pkg::WORK_FRAC - atpc_pkg::PROD_SHIFT));
        b20  = longint'(20) << atpc_pkg::TEMP_FRAC_BITS;
        b116 = longint'(116) << atpc_pkg::TEMP_FRAC_BITS;
        b477 = longint'(477) << atpc_pkg::TEMP_FRAC_BITS;
        b700 = longint'(700) << atpc_pkg::TEMP_FRAC_BITS;
        kd = 0;
        hd = 0;
        dd = 0;
        if (tv <= b116)
            kc = fix_coef(775554, 4, 0, 0);
        else if (tv <= b477)
        begin
            kc = eval_curve(PL_COND_MID, 4, u);
            kd = eval_curve(PL_COND_MID_D, 3, u);
        end
        else if (tv < b700)
        begin
            kc = eval_curve(PL_COND_HI, 3, u);
            kd = eval_curve(PL_COND_HI_D, 2, u);
        end
        else
            kc = fix_coef(167531, 3, 0, 0);
        if (tv <= b116)
            hc = fix_coef(57212, 2, 0, 0);
        else if (tv <= b700)
        begin
            hc = eval_curve(PL_HEAT, 5, u);
            hd = eval_curve(PL_HEAT_D, 4, u);
        end
        else
            hc = fix_coef(117207, 2, 0, 0);
        if (tv <= b20)
            dc = eval_curve(PL_DENS_LOW, 2, u);
        else if (tv <= b700)
        begin
            dc = eval_curve(PL_DENS, 6, u);
            dd = eval_curve(PL_DENS_D, 5, u);
        end
        else
            dc = fix_coef(263462, 2, 0, 0);
        p.cond   = to_q16_32(kc);
        p.cond_d = to_q16_32(kd);
        p.heat   = to_q16_32(hc);
        p.heat_d = to_q16_32(hd);
        p.dens   = to_q16_32(dc);
        p.dens_d = to_q16_32(dd);
        p.bad    = (tv <= 0);
        return p;
    endfunction

    task automatic check_field(string name, logic signed [47:0] exp_v, logic signed [47:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
        end
    endtask

    // Offer one request and wait for it to be taken; record what it should produce.
    task automatic send_request(logic signed [31:0] t, props_t expected);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 5);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    = 1'b1;
        temperature = t;
        do
            @(posedge clk);
        while (!in_ready);
        pending_props.push_back(expected);
        n_sent++;
        @(negedge clk);
    endtask

    function automatic logic signed [31:0] random_temp();
        int sel;
        int bp;
        sel = $urandom_range(0, 9);
        if (sel < 6)
            return $urandom_range(0, 760 << 16);
        if (sel < 8)
        begin
            case ($urandom_range(0, 3))
                0: bp = 20;
                1: bp = 116;
                2: bp = 477;
                default: bp = 700;
            endcase
            return (bp << 16) + $signed($urandom_range(0, 64)) - 32;
        end
        return $urandom;
    endfunction

    drow_t directed_rows[] = '{
        '{32'sd0,                1'b1, 1'b1},
        '{32'sd1,                1'b0, 1'b1},
        '{-32'sd1,               1'b1, 1'b1},
        '{32'sh8000_0000,        1'b1, 1'b1},
        '{32'sh7FFF_FFFF,        1'b0, 1'b1},
        '{32'sd20 <<< 16,        1'b0, 1'b1},
        '{(32'sd20 <<< 16) + 1,  1'b0, 1'b0},
        '{32'sd116 <<< 16,       1'b0, 1'b0},
        '{(32'sd116 <<< 16) + 1, 1'b0, 1'b0},
        '{32'sd300 <<< 16,       1'b0, 1'b0},
        '{(32'sd477 <<< 16) - 1, 1'b0, 1'b0},
        '{32'sd477 <<< 16,       1'b0, 1'b0},
        '{(32'sd477 <<< 16) + 1, 1'b0, 1'b0},
        '{(32'sd700 <<< 16) - 1, 1'b0, 1'b0},
        '{32'sd700 <<< 16,       1'b0, 1'b0},
        '{(32'sd700 <<< 16) + 1, 1'b0, 1'b1},
        '{32'sd1000 <<< 16,      1'b0, 1'b1},
        '{-(32'sd50 <<< 16),     1'b1, 1'b1},
        '{32'sd10 <<< 16,        1'b0, 1'b1}
    };

    initial
    begin
        props_t e;
        logic signed [31:0] t;
        clk         = 1'b0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        temperature = '0;
        out_ready   = 1'b0;
        hold_out    = 1'b0;
        no_idle     = 1'b0;
        errors      = 0;
        n_sent      = 0;
        n_checked   = 0;
        n_bad_seen  = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        foreach (directed_rows[i])
        begin
            e     = predict_props(directed_rows[i].temp);
            e.bad = directed_rows[i].bad;
            if (directed_rows[i].flat)
            begin
                e.cond_d = '0;
                e.heat_d = '0;
                e.dens_d = '0;
            end
            send_request(directed_rows[i].temp, e);
        end

        for (int n = 0; n < N_RANDOM; n++)
        begin
            // Back-to-back stretches, a long receiver stall, and a drain pause.
            no_idle = (n >= 100 && n < 200) || (n >= 500 && n < 560);
            if (n == 300)
                hold_out = 1'b1;
            if (n == 400)
            begin
                in_valid = 1'b0;
                wait (pending_props.size() == 0);
                @(negedge clk);
            end
            t = random_temp();
            send_request(t, predict_props(t));
        end
        in_valid = 1'b0;

        wait (pending_props.size() == 0);
        repeat (40) @(posedge clk);
        $display("Sent %0d temperatures (%0d not above zero), checked %0d results,",
                 n_sent, n_bad_seen, n_checked);
        $display("covering every segment edge, range extremes and output stalls.");
        if (errors == 0 && pending_props.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Receiver: random hold-off per result, plus one long stall on request.
    initial
    begin
        int wait_n;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_out)
            begin
                out_ready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_out = 1'b0;
            end
            wait_n = no_idle ? 0 : $urandom_range(0, 5);
            if (wait_n > 0)
            begin
                out_ready = 1'b0;
                repeat (wait_n) @(negedge clk);
            end
            out_ready = 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
        end
    end

    always @(posedge clk)
    begin
        props_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_props.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none actual cond %0d",
                         $time, conductivity);
            end
            else
            begin
                e = pending_props.pop_front();
                n_checked++;
                if (e.bad)
                    n_bad_seen++;
                check_field("conductivity", e.cond, conductivity);
                check_field("conductivity_slope", e.cond_d, conductivity_slope);
                check_field("heat_capacity", e.heat, heat_capacity);
                check_field("heat_capacity_slope", e.heat_d, heat_capacity_slope);
                check_field("mass_density", e.dens, mass_density);
                check_field("mass_density_slope", e.dens_d, mass_density_slope);
                check_field("bad_temperature", 48'(e.bad), 48'(bad_temperature));
            end
        end
    end

    initial
    begin
        #5ms;
        $display("Timeout with %0d results outstanding", pending_props.size());
        $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
design/atpc_pkg.sv
design/atpc_cell.sv
design/alloy_thermal_property_curves_core.sv
dv/alloy_thermal_property_curves_core_tb.sv
